// ----- rtl/bounded_deque_with_search_assert.svh -----
// Assertion macros for the bounded deque with search.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

// assert that a implies b at every clock edge out of reset
`define BDQ_ASSERT_IMPL(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// assert that a implies b in the next cycle
`define BDQ_ASSERT_NEXT(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ----- rtl/bdq_pkg.sv -----
// Package for the bounded deque with search: sizes, op and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bdq_pkg;
    localparam int CAPACITY = 16;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int VAL_W = 32;
    localparam int LINK_W = 2 * SLOT_W;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LOOKUP     = 3'd4,
        OP_DELETE     = 3'd5,
        OP_MINMAX     = 3'd6,
        OP_NONE       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    localparam logic [VAL_W-1:0] VAL_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_NEG_MIN = 32'h8000_0000;
endpackage
`default_nettype wire

// ----- rtl/bounded_deque_with_search.sv -----
// Top level of the bounded deque with search: sequencer over value and link RAMs.
// Depends on bdq_pkg, bdq_ram and bounded_deque_with_search_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time: a word is taken only in idle with the result register
// empty. A full push, an empty pop or search and op 7 load the result straight
// from idle; a push on an empty list passes through the done state, any other
// push writes the new entry, then reads and rewrites the neighbor's links. A pop
// reads the links of the removed entry, then, unless it was the last entry, reads
// and rewrites the neighbor's links. Lookup walks from the head until a hit or the
// last entry, min/max over the whole list, at one value and link read per entry.
// Delete walks likewise, and each neighbor whose link changes costs a read and a
// write of the link RAM. The next word can be taken in the cycle after the result is accepted.
module bounded_deque_with_search (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // op[2:0], value[34:3], key[66:35], zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // status[1:0], found[2], length[7:3],
                                        // min_value[39:8], max_value[71:40]
);
    import bdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_WALK_CHK, S_UNL_CHK, S_FIXP_RD, S_FIXP_WR, S_FIXN_RD, S_FIXN_WR,
        S_DONE
    } state_t;

    state_t state_reg;
    logic [CAPACITY-1:0] free_reg;
    slot_t head_reg, tail_reg, cur_reg, unl_reg;
    slot_t fixp_addr_reg, fixp_val_reg, fixn_addr_reg, fixn_val_reg;
    logic fixn_need_reg;
    cnt_t count_reg, step_reg;
    op_t op_reg;
    logic [VAL_W-1:0] key_reg, mn_reg, mx_reg;
    logic out_valid_reg;
    logic [71:0] out_reg;

    // value RAM and link RAM {next, prev}
    logic v_we, l_we;
    slot_t v_waddr, v_raddr, l_waddr, l_raddr;
    logic [VAL_W-1:0] v_wdata, v_rdata;
    logic [LINK_W-1:0] l_wdata, l_rdata;

    bdq_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata));
    bdq_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_link (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata));

    logic in_acc;
    op_t in_op;
    logic [VAL_W-1:0] in_value, in_key;
    slot_t free_slot;
    logic any_free;
    logic is_push, push_ok, hit, walk_last;
    slot_t nx, pv;

    assign in_op = op_t'(s_tdata[2:0]);
    assign in_value = s_tdata[34:3];
    assign in_key = s_tdata[66:35];
    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_acc = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;
    assign nx = l_rdata[LINK_W-1:SLOT_W];
    assign pv = l_rdata[SLOT_W-1:0];
    assign is_push = (in_op == OP_PUSH_FRONT) || (in_op == OP_PUSH_BACK);
    assign push_ok = (count_reg < cnt_t'(CAPACITY)) && any_free;
    assign hit = (v_rdata == key_reg);
    assign walk_last = (step_reg + 1'b1 == count_reg);

    always_comb
    begin
        free_slot = '0;
        any_free = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                free_slot = slot_t'(i);
                any_free = 1'b1;
            end
        end
    end

    function automatic logic [71:0] pack(status_t st, logic f, cnt_t n,
                                         logic [VAL_W-1:0] mn, logic [VAL_W-1:0] mx);
        pack = {mx, mn, n, f, st};
    endfunction

    // RAM port control
    always_comb
    begin
        v_we = 1'b0;
        v_waddr = free_slot;
        v_wdata = in_value;
        l_we = 1'b0;
        l_waddr = free_slot;
        l_wdata = '0;
        v_raddr = head_reg;
        l_raddr = head_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && is_push && push_ok)
                begin
                    v_we = 1'b1;
                    l_we = 1'b1;
                    if (count_reg == '0)
                        l_wdata = {free_slot, free_slot};
                    else if (in_op == OP_PUSH_FRONT)
                        l_wdata = {head_reg, free_slot};
                    else
                        l_wdata = {free_slot, tail_reg};
                end
                if (in_op == OP_POP_BACK)
                    l_raddr = tail_reg;
            end
            S_WALK_CHK:
            begin
                v_raddr = nx;
                l_raddr = (op_reg == OP_DELETE && hit) ? cur_reg : nx;
            end
            S_FIXP_RD:
            begin
                l_raddr = fixp_addr_reg;
            end
            S_FIXP_WR:
            begin
                l_we = 1'b1;
                l_waddr = fixp_addr_reg;
                l_wdata = {fixp_val_reg, pv};
            end
            S_FIXN_RD:
            begin
                l_raddr = fixn_addr_reg;
            end
            S_FIXN_WR:
            begin
                l_we = 1'b1;
                l_waddr = fixn_addr_reg;
                l_wdata = {nx, fixn_val_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            free_reg <= '1;
            head_reg <= '0;
            tail_reg <= '0;
            cur_reg <= '0;
            unl_reg <= '0;
            fixp_addr_reg <= '0;
            fixp_val_reg <= '0;
            fixn_addr_reg <= '0;
            fixn_val_reg <= '0;
            fixn_need_reg <= 1'b0;
            count_reg <= '0;
            step_reg <= '0;
            op_reg <= OP_NONE;
            key_reg <= '0;
            mn_reg <= '0;
            mx_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        op_reg <= in_op;
                        key_reg <= in_key;
                        mn_reg <= VAL_POS_MAX;
                        mx_reg <= VAL_NEG_MIN;
                        step_reg <= '0;
                        cur_reg <= head_reg;
                        unique case (in_op)
                            OP_PUSH_FRONT, OP_PUSH_BACK:
                            begin
                                if (push_ok)
                                begin
                                    free_reg[free_slot] <= 1'b0;
                                    count_reg <= count_reg + 1'b1;
                                    fixn_need_reg <= 1'b0;
                                    if (count_reg == '0)
                                    begin
                                        head_reg <= free_slot;
                                        tail_reg <= free_slot;
                                        state_reg <= S_DONE;
                                    end
                                    else if (in_op == OP_PUSH_FRONT)
                                    begin
                                        head_reg <= free_slot;
                                        fixn_addr_reg <= head_reg;
                                        fixn_val_reg <= free_slot;
                                        state_reg <= S_FIXN_RD;
                                    end
                                    else
                                    begin
                                        tail_reg <= free_slot;
                                        fixp_addr_reg <= tail_reg;
                                        fixp_val_reg <= free_slot;
                                        state_reg <= S_FIXP_RD;
                                    end
                                end
                                else
                                begin
                                    out_reg <= pack(ST_FULL, 1'b0, count_reg, '0, '0);
                                    out_valid_reg <= 1'b1;
                                end
                            end
                            OP_POP_FRONT, OP_POP_BACK:
                            begin
                                if (count_reg == '0)
                                begin
                                    out_reg <= pack(ST_EMPTY, 1'b0, count_reg, '0, '0);
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    unl_reg <= (in_op == OP_POP_BACK) ? tail_reg : head_reg;
                                    state_reg <= S_UNL_CHK;
                                end
                            end
                            OP_LOOKUP, OP_DELETE, OP_MINMAX:
                            begin
                                if (count_reg == '0)
                                begin
                                    out_reg <= (in_op == OP_MINMAX) ?
                                        pack(ST_EMPTY, 1'b0, count_reg,
                                             VAL_POS_MAX, VAL_NEG_MIN) :
                                        pack(ST_NOT_FOUND, 1'b0, count_reg, '0, '0);
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_WALK_CHK;
                                end
                            end
                            default:
                            begin
                                out_reg <= pack(ST_OK, 1'b0, count_reg, '0, '0);
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_WALK_CHK:
                begin
                    // RAM outputs hold entry cur_reg
                    step_reg <= step_reg + 1'b1;
                    if (op_reg == OP_MINMAX)
                    begin
                        cur_reg <= nx;
                        if ($signed(v_rdata) < $signed(mn_reg))
                            mn_reg <= v_rdata;
                        if ($signed(v_rdata) > $signed(mx_reg))
                            mx_reg <= v_rdata;
                        if (walk_last)
                            state_reg <= S_DONE;
                    end
                    else if (hit)
                    begin
                        if (op_reg == OP_DELETE)
                        begin
                            unl_reg <= cur_reg;
                            state_reg <= S_UNL_CHK;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else if (walk_last)
                    begin
                        out_reg <= pack(ST_NOT_FOUND, 1'b0, count_reg, '0, '0);
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cur_reg <= nx;
                    end
                end
                S_UNL_CHK:
                begin
                    // link RAM output holds the links of unl_reg
                    free_reg[unl_reg] <= 1'b1;
                    count_reg <= count_reg - 1'b1;
                    fixp_addr_reg <= pv;
                    fixp_val_reg <= nx;
                    fixn_addr_reg <= nx;
                    fixn_val_reg <= pv;
                    fixn_need_reg <= (unl_reg != tail_reg);
                    if (count_reg == cnt_t'(1))
                    begin
                        head_reg <= '0;
                        tail_reg <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (unl_reg == head_reg)
                            head_reg <= nx;
                        if (unl_reg == tail_reg)
                            tail_reg <= pv;
                        if (unl_reg != head_reg)
                            state_reg <= S_FIXP_RD;
                        else
                            state_reg <= S_FIXN_RD;
                    end
                end
                S_FIXP_RD:
                begin
                    state_reg <= S_FIXP_WR;
                end
                S_FIXP_WR:
                begin
                    state_reg <= fixn_need_reg ? S_FIXN_RD : S_DONE;
                end
                S_FIXN_RD:
                begin
                    state_reg <= S_FIXN_WR;
                end
                S_FIXN_WR:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    out_reg <= (op_reg == OP_MINMAX) ?
                        pack(ST_OK, 1'b0, count_reg, mn_reg, mx_reg) :
                        pack(ST_OK, (op_reg == OP_LOOKUP || op_reg == OP_DELETE),
                             count_reg, '0, '0);
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `include "bounded_deque_with_search_assert.svh"
    `BDQ_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= cnt_t'(CAPACITY), "count over capacity")
    `BDQ_ASSERT_IMPL(a_idle_ready, s_tready, state_reg == S_IDLE, "ready outside idle")
    `BDQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `BDQ_ASSERT_NEXT(a_one_word, s_tvalid && s_tready, !s_tready, "second word taken")
endmodule
`default_nettype wire

// ----- rtl/bdq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for the bounded deque with search: directed table, fill and empty, then random requests.
// Depends on bdq_pkg and the bounded_deque_with_search top level.
`timescale 1ns / 1ps
module tb_top;
    import bdq_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] max_value;
        logic [VAL_W-1:0] min_value;
        logic [4:0]       length;
        logic             found;
        status_t          status;
    } result_t;

    typedef struct {
        op_t              op;
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] key;
        bit               typed;
        status_t          status;
        logic             found;
        logic [4:0]       length;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    bounded_deque_with_search dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // shadow of the deque, front at index 0
    logic [VAL_W-1:0] deque_q[$];
    result_t          pending_results[$];
    int               error_count;
    int               words_checked;
    int               op_counts[8];
    longint           cycle_count;
    bit               quiet_ready;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic result_t apply_request(op_t op, logic [VAL_W-1:0] value,
                                              logic [VAL_W-1:0] key);
        result_t r;
        int      hit;
        r = '0;
        r.status = ST_OK;
        hit = -1;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (deque_q.size() >= CAPACITY)
                    r.status = ST_FULL;
                else if (op == OP_PUSH_FRONT)
                    deque_q.push_front(value);
                else
                    deque_q.push_back(value);
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (deque_q.size() == 0)
                    r.status = ST_EMPTY;
                else if (op == OP_POP_FRONT)
                    void'(deque_q.pop_front());
                else
                    void'(deque_q.pop_back());
            end
            OP_LOOKUP, OP_DELETE:
            begin
                foreach (deque_q[i])
                    if (hit < 0 && deque_q[i] == key)
                        hit = i;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.found = 1'b1;
                    if (op == OP_DELETE)
                        deque_q.delete(hit);
                end
            end
            OP_MINMAX:
            begin
                r.min_value = VAL_POS_MAX;
                r.max_value = VAL_NEG_MIN;
                if (deque_q.size() == 0)
                    r.status = ST_EMPTY;
                foreach (deque_q[i])
                begin
                    if ($signed(deque_q[i]) < $signed(r.min_value))
                        r.min_value = deque_q[i];
                    if ($signed(deque_q[i]) > $signed(r.max_value))
                        r.max_value = deque_q[i];
                end
            end
            default:
                ;
        endcase
        r.length = 5'(deque_q.size());
        return r;
    endfunction

    task automatic send_word(op_t op, logic [VAL_W-1:0] value, logic [VAL_W-1:0] key,
                             bit idle_ok);
        while (idle_ok && $urandom_range(99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, key, value, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(apply_request(op, value, key));
        op_counts[op]++;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(4))
            0: return VAL_POS_MAX;
            1: return VAL_NEG_MIN;
            2: return $urandom_range(7) - 3;
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // drain the result stream and compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            m_tready <= quiet_ready || ($urandom_range(99) >= 16);
            if (m_tvalid && m_tready)
            begin
                result_t got;
                result_t want;
                got = m_tdata;
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result %h", $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    words_checked++;
                    if (got !== want)
                    begin
                        $display("%0t mismatch expected st=%0d f=%0d len=%0d min=%h max=%h",
                                 $time, want.status, want.found, want.length,
                                 want.min_value, want.max_value);
                        $display("%0t          actual   st=%0d f=%0d len=%0d min=%h max=%h",
                                 $time, got.status, got.found, got.length,
                                 got.min_value, got.max_value);
                        error_count++;
                    end
                end
            end
            if (cycle_count > 400000)
            begin
                $display("timeout at %0t", $time);
                $display("status: fail");
                $finish;
            end
        end
    end

    row_t directed[$];

    task automatic add_row(op_t op, logic [VAL_W-1:0] value, logic [VAL_W-1:0] key,
                           bit typed, status_t st, logic found, logic [4:0] len);
        row_t row;
        row = '{op, value, key, typed, st, found, len};
        directed.push_back(row);
    endtask

    initial
    begin
        int  fill;
        int  sent;
        int  lo;
        result_t typed_result;
        error_count = 0;
        words_checked = 0;
        cycle_count = 0;
        quiet_ready = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(OP_POP_FRONT, 0, 0, 1, ST_EMPTY, 0, 0);
        add_row(OP_POP_BACK, 0, 0, 1, ST_EMPTY, 0, 0);
        add_row(OP_LOOKUP, 0, 0, 1, ST_NOT_FOUND, 0, 0);
        add_row(OP_DELETE, 0, 32'hFFFF_FFFF, 1, ST_NOT_FOUND, 0, 0);
        add_row(OP_MINMAX, 0, 0, 0, ST_OK, 0, 0);
        add_row(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK, 0, 0);
        add_row(OP_PUSH_FRONT, VAL_POS_MAX, 0, 1, ST_OK, 0, 1);
        add_row(OP_POP_FRONT, 0, 0, 1, ST_OK, 0, 0);
        add_row(OP_PUSH_BACK, VAL_NEG_MIN, 0, 1, ST_OK, 0, 1);
        add_row(OP_POP_BACK, 0, 0, 1, ST_OK, 0, 0);
        add_row(OP_PUSH_BACK, VAL_NEG_MIN, 0, 0, ST_OK, 0, 0);
        add_row(OP_PUSH_FRONT, VAL_POS_MAX, 0, 0, ST_OK, 0, 0);
        add_row(OP_PUSH_BACK, 32'hFFFF_FFFF, 0, 0, ST_OK, 0, 0);
        add_row(OP_MINMAX, 0, 0, 0, ST_OK, 0, 0);
        add_row(OP_LOOKUP, 0, VAL_NEG_MIN, 0, ST_OK, 0, 0);
        add_row(OP_DELETE, 0, VAL_POS_MAX, 0, ST_OK, 0, 0);
        add_row(OP_DELETE, 0, 32'h1234_5678, 0, ST_OK, 0, 0);
        foreach (directed[i])
        begin
            send_word(directed[i].op, directed[i].value, directed[i].key, 1);
            typed_result = pending_results[$];
            if (directed[i].typed && (typed_result.status != directed[i].status ||
                typed_result.found != directed[i].found ||
                typed_result.length != directed[i].length))
            begin
                $display("%0t table row %0d disagrees with predictor", $time, i);
                error_count++;
            end
        end
        // fill to capacity, overflow, then empty from both ends
        for (fill = 0; fill < CAPACITY + 2; fill++)
            send_word(fill[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value(), 0, 1);
        send_word(OP_MINMAX, 0, 0, 1);
        for (fill = 0; fill < CAPACITY + 1; fill++)
            send_word(fill[0] ? OP_POP_FRONT : OP_POP_BACK, 0, 0, 1);
        drain();

        sent = 0;
        while (sent < 900)
        begin
            op_t op;
            logic [VAL_W-1:0] key;
            quiet_ready = (sent >= 300 && sent < 400);
            lo = (deque_q.size() < 4) ? 2 : 0;
            case ($urandom_range(9, lo))
                0, 1: op = OP_POP_FRONT;
                2, 3: op = OP_POP_BACK;
                4, 5: op = OP_PUSH_FRONT;
                6, 7: op = OP_PUSH_BACK;
                default: op = op_t'($urandom_range(7, 4));
            endcase
            if ($urandom_range(3) == 0)
                op = op_t'($urandom_range(7));
            if (deque_q.size() != 0 && $urandom_range(2) != 0)
                key = deque_q[$urandom_range(deque_q.size() - 1)];
            else
                key = pick_value();
            send_word(op, pick_value(), key, !quiet_ready);
            sent++;
            if (sent == 450)
                drain();
        end
        drain();
        repeat (60)
            @(posedge clk);
        $display("checked %0d result words; ops push %0d/%0d pop %0d/%0d",
                 words_checked, op_counts[0], op_counts[1], op_counts[2], op_counts[3]);
        $display("lookup %0d delete %0d minmax %0d unused %0d",
                 op_counts[4], op_counts[5], op_counts[6], op_counts[7]);
        if (error_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
